[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SEM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define SEM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SEM_ASSERT(lbl, clk, rstn, prop)
`define SEM_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[hw/rtl/sem_pkg.sv]
// ----------------------------------------------------------------------------
// sem_pkg
// Shared constants and types of the Sobel edge magnitude core.
// ----------------------------------------------------------------------------
`default_nettype none

package sem_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 16;
  localparam int CFG_W      = 16;
  localparam int PIX_W      = 24;
  localparam int CH_W       = 8;
  localparam int ROOT_W     = 8;
  localparam int GRAD_W     = 11;
  localparam int SQ_W       = 16;
  localparam int SUM_W      = 22;
  localparam int SAT_LIMIT  = 65280;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [2:0][PIX_W-1:0] col_t;   // index 0 = top row
  typedef logic [8:0][PIX_W-1:0] win_t;   // index row * 3 + column

  typedef struct packed {
    logic              sat;
    logic [SQ_W-1:0]   s;
    logic [ROOT_W-1:0] n;
  } sq_lane_t;

  typedef struct packed {
    logic               valid;
    logic               fe;
    sq_lane_t [2:0]     lane;   // 0 = red, 1 = green, 2 = blue
  } sq_word_t;

  typedef struct packed {
    logic              pix;
    pix_t              px;
    logic [ADDR_W-1:0] addr;
    logic              emit;
    logic              zero_col;
    logic              fe;
    logic [2:0]        row_ok;
    logic [2:0]        col_ok;
  } ctl_t;

endpackage

`default_nettype wire

[hw/rtl/sem_win_cell.sv]
// ----------------------------------------------------------------------------
// sem_win_cell
// One column of the 3x3 window; takes its neighbour's column on a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_win_cell (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          clr_i,
  input  wire logic          shift_i,
  input  wire sem_pkg::col_t col_i,
  output sem_pkg::col_t      col_o
);
  import sem_pkg::*;

  col_t col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (clr_i) begin
      col_q <= '0;
    end else if (shift_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

endmodule

`default_nettype wire

[hw/rtl/sem_grad.sv]
// ----------------------------------------------------------------------------
// sem_grad
// Sobel Gx/Gy per channel, then Gx^2 + Gy^2 with saturation flag.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_grad (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire logic          fe_i,
  input  wire sem_pkg::win_t win_i,
  output logic               busy_o,
  output sem_pkg::sq_word_t  word_o
);
  import sem_pkg::*;

  logic signed [GRAD_W-1:0] gx_d [3];
  logic signed [GRAD_W-1:0] gy_d [3];
  logic signed [GRAD_W-1:0] gx_q [3];
  logic signed [GRAD_W-1:0] gy_q [3];
  logic                     v1_q;
  logic                     fe1_q;
  logic signed [GRAD_W-1:0] e [9];
  logic signed [SUM_W-1:0]  gx2;
  logic signed [SUM_W-1:0]  gy2;
  logic [SUM_W-1:0]         ssum;
  sq_word_t                 word_d;
  sq_word_t                 word_q;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 9; k++) begin
        e[k] = $signed({3'b000, win_i[k][PIX_W-1-CH_W*ch -: CH_W]});
      end
      gx_d[ch] = (e[2] - e[0]) + ((e[5] - e[3]) <<< 1) + (e[8] - e[6]);
      gy_d[ch] = (e[6] + (e[7] <<< 1) + e[8]) - (e[0] + (e[1] <<< 1) + e[2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    fe1_q <= fe_i;
    gx_q  <= gx_d;
    gy_q  <= gy_d;
  end

  always_comb begin
    gx2          = '0;
    gy2          = '0;
    ssum         = '0;
    word_d.valid = v1_q;
    word_d.fe    = fe1_q;
    for (int ch = 0; ch < 3; ch++) begin
      gx2  = gx_q[ch] * gx_q[ch];
      gy2  = gy_q[ch] * gy_q[ch];
      ssum = SUM_W'(gx2 + gy2);
      word_d.lane[ch].sat = ssum > SUM_W'(SAT_LIMIT);
      word_d.lane[ch].s   = ssum[SQ_W-1:0];
      word_d.lane[ch].n   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
    end else begin
      word_q <= word_d;
    end
  end

  assign busy_o = v1_q;
  assign word_o = word_q;

endmodule

`default_nettype wire

[hw/rtl/sem_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// sem_sqrt_cell
// One bit of the integer square root, three channels side by side.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_sqrt_cell (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [sem_pkg::ROOT_W-1:0] bit_i,
  input  wire sem_pkg::sq_word_t          word_i,
  output sem_pkg::sq_word_t               word_o
);
  import sem_pkg::*;

  logic [ROOT_W-1:0] t;
  logic [SQ_W-1:0]   tt;
  sq_word_t          word_d;
  sq_word_t          word_q;

  always_comb begin
    word_d = word_i;
    t      = '0;
    tt     = '0;
    for (int ch = 0; ch < 3; ch++) begin
      t  = word_i.lane[ch].n | bit_i;
      tt = t * t;
      if (tt <= word_i.lane[ch].s) begin
        word_d.lane[ch].n = t;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
    end else begin
      word_q <= word_d;
    end
  end

  assign word_o = word_q;

endmodule

`default_nettype wire

[hw/rtl/sobel_edge_magnitude_rgb_core.sv]
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb_core
// 3x3 Sobel edge magnitude on an RGB raster stream, two line stores.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (operation, RGB) arrive on in_valid_i/in_ready_o in raster
//   order; operation 1 is a drain tick that releases one pending result at
//   frame end. Result words leave on out_valid_o/out_ready_i, one row and one
//   pixel behind the input. cfg_we_i writes width (index 0) or height
//   (index 1) and restarts the frame.
//   A drain tick that first pushes the window on a single-row frame passes
//   through a pre-shift step before the window step. Only one word is in
//   flight at a time: a word that produces a result passes the window step,
//   the two gradient stages and the eight-cell square-root chain before the
//   next word is taken.
//   Reset clears position, pending count and window; width 640, height 480.
//   A stalled receiver holds the output word; one more result is parked in
//   a skid register and input is held off until it drains.
`default_nettype none
`include "assert_macros.svh"

module sobel_edge_magnitude_rgb_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic                         cfg_idx_i,
  input  wire logic [sem_pkg::CFG_W-1:0]    cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         operation_i,
  input  wire logic [sem_pkg::CH_W-1:0]     red_in_i,
  input  wire logic [sem_pkg::CH_W-1:0]     green_in_i,
  input  wire logic [sem_pkg::CH_W-1:0]     blue_in_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [sem_pkg::CH_W-1:0]          red_edge_o,
  output logic [sem_pkg::CH_W-1:0]          green_edge_o,
  output logic [sem_pkg::CH_W-1:0]          blue_edge_o,
  output logic                              frame_end_o
);
  import sem_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PRE  = 2'd1;
  localparam logic [1:0] S_EX   = 2'd2;

  typedef struct packed {
    logic              fe;
    logic [2:0][CH_W-1:0] edge_px;
  } res_t;

  logic [1:0]          state_q, state_d;
  logic [WIDTH_W-1:0]  w_q;
  logic [HEIGHT_W-1:0] h_q;
  logic [ADDR_W-1:0]   col_q, col_d;
  logic [HEIGHT_W-1:0] row_q, row_d;
  logic [WIDTH_W-1:0]  pend_q, pend_d;
  ctl_t                ctl_q, ctl_d;

  logic [WIDTH_W-1:0]  ew, ew1;
  logic [HEIGHT_W-1:0] eh;

  // pixel path
  logic [ADDR_W-1:0]   c_eff;
  logic                c_first, p_emit;
  logic [WIDTH_W-1:0]  c1;
  logic [HEIGHT_W:0]   r1;
  logic [WIDTH_W-1:0]  pbase;
  // drain path
  logic                d_ok, d_pre, d_edge;
  logic [WIDTH_W-1:0]  pcl, vc;
  // shared neighbourhood limits
  logic signed [HEIGHT_W+1:0] pr, rr0, rr2, eh_s;
  logic [WIDTH_W-1:0]  pc;
  logic                in_acc;

  logic [ADDR_W-1:0]   rd_addr;
  pix_t                mem_a [MAX_WIDTH];
  pix_t                mem_b [MAX_WIDTH];
  pix_t                rd_a_q, rd_b_q;

  col_t                new_col, wc0, wc1, wc2;
  logic                win_shift;
  win_t                em_d, em_q;
  logic                em_v_q, em_fe_q;

  logic                grad_busy;
  sq_word_t            chain [ROOT_W+1];
  logic                pipe_busy;

  res_t                res;
  logic [ROOT_W:0]     rnd;
  logic [SQ_W:0]       lim;
  logic                res_v;
  res_t                out_q, skid_q;
  logic                out_v_q, skid_v_q;
  logic                pop;

  assign ew   = (w_q == '0) ? WIDTH_W'(1) :
                (w_q > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : w_q;
  assign ew1  = ew + WIDTH_W'(1);
  assign eh   = (h_q == '0) ? HEIGHT_W'(1) : h_q;
  assign eh_s = $signed({2'b00, eh});

  assign in_ready_o = (state_q == S_IDLE) && !pipe_busy && !skid_v_q;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    c_eff   = ({1'b0, col_q} >= ew) ? '0 : col_q;
    c_first = (c_eff == '0);
    p_emit  = c_first ? (row_q >= HEIGHT_W'(2)) : (row_q >= HEIGHT_W'(1));
    c1      = {1'b0, c_eff} + WIDTH_W'(1);
    r1      = {1'b0, row_q} + 17'd1;
    pbase   = (row_q == '0 && col_q == '0) ? '0 : pend_q;

    d_ok    = (pend_q != '0) && (row_q == '0) && (col_q == '0);
    pcl     = (pend_q > ew1) ? ew1 : pend_q;
    vc      = ew1 - pcl;
    d_pre   = (eh == HEIGHT_W'(1)) && (pcl == ew);
    d_edge  = (vc == '0) || (vc == ew);

    ctl_d = '0;
    if (!operation_i) begin
      pr = c_first ? $signed({2'b00, row_q}) - 18'sd2 : $signed({2'b00, row_q}) - 18'sd1;
      pc = c_first ? ew - WIDTH_W'(1) : {1'b0, c_eff} - WIDTH_W'(1);
      ctl_d.pix      = 1'b1;
      ctl_d.px       = {red_in_i, green_in_i, blue_in_i};
      ctl_d.addr     = c_eff;
      ctl_d.emit     = p_emit;
      ctl_d.zero_col = c_first;
      ctl_d.fe       = 1'b0;
    end else begin
      pr = (d_edge && vc == '0) ? eh_s - 18'sd2 : eh_s - 18'sd1;
      pc = d_edge ? ew - WIDTH_W'(1) : vc - WIDTH_W'(1);
      ctl_d.pix      = 1'b0;
      ctl_d.px       = '0;
      ctl_d.addr     = d_edge ? '0 : vc[ADDR_W-1:0];
      ctl_d.emit     = 1'b1;
      ctl_d.zero_col = d_edge;
      ctl_d.fe       = (pcl == WIDTH_W'(1));
    end
    rr0 = pr - 18'sd1;
    rr2 = pr + 18'sd1;
    ctl_d.row_ok[0] = !rr0[HEIGHT_W+1] && (rr0 < eh_s);
    ctl_d.row_ok[1] = !pr[HEIGHT_W+1] && (pr < eh_s);
    ctl_d.row_ok[2] = !rr2[HEIGHT_W+1] && (rr2 < eh_s);
    ctl_d.col_ok[0] = (pc != '0);
    ctl_d.col_ok[1] = 1'b1;
    ctl_d.col_ok[2] = ({1'b0, pc} + 12'd1) < {1'b0, ew};
  end

  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    row_d   = row_q;
    pend_d  = pend_q;
    rd_addr = ctl_q.addr;
    unique case (state_q)
      S_IDLE: begin
        if (!operation_i) begin
          rd_addr = c_eff;
        end else begin
          rd_addr = (d_pre || d_edge) ? '0 : vc[ADDR_W-1:0];
        end
        if (in_acc) begin
          if (!operation_i) begin
            state_d = S_EX;
            if (c1 >= ew) begin
              col_d = '0;
              row_d = (r1 >= {1'b0, eh}) ? '0 : r1[HEIGHT_W-1:0];
            end else begin
              col_d = c1[ADDR_W-1:0];
            end
            pend_d = (!p_emit && pbase < ew1) ? pbase + WIDTH_W'(1) : pbase;
          end else if (d_ok) begin
            state_d = d_pre ? S_PRE : S_EX;
            pend_d  = pcl - WIDTH_W'(1);
          end
        end
      end
      S_PRE:   state_d = S_EX;
      S_EX:    state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      w_q     <= WIDTH_W'(640);
      h_q     <= HEIGHT_W'(480);
      col_q   <= '0;
      row_q   <= '0;
      pend_q  <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_WIDTH:  w_q <= cfg_data_i[WIDTH_W-1:0];
          REG_HEIGHT: h_q <= cfg_data_i;
          default:    w_q <= w_q;
        endcase
        col_q  <= '0;
        row_q  <= '0;
        pend_q <= '0;
      end else begin
        col_q  <= col_d;
        row_q  <= row_d;
        pend_q <= pend_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ctl_q <= ctl_d;
    end
  end

  // line stores: store b takes the old row of store a
  always_ff @(posedge clk_i) begin
    if (state_q == S_EX && ctl_q.pix) begin
      mem_a[ctl_q.addr] <= ctl_q.px;
      mem_b[ctl_q.addr] <= rd_a_q;
    end
    rd_a_q <= mem_a[rd_addr];
    rd_b_q <= mem_b[rd_addr];
  end

  assign new_col   = {ctl_q.px, rd_a_q, rd_b_q};
  assign win_shift = (state_q == S_PRE) || (state_q == S_EX);

  sem_win_cell u_col2 (
    .clk_i, .rst_ni, .clr_i(cfg_we_i), .shift_i(win_shift), .col_i(new_col), .col_o(wc2)
  );
  sem_win_cell u_col1 (
    .clk_i, .rst_ni, .clr_i(cfg_we_i), .shift_i(win_shift), .col_i(wc2), .col_o(wc1)
  );
  sem_win_cell u_col0 (
    .clk_i, .rst_ni, .clr_i(cfg_we_i), .shift_i(win_shift), .col_i(wc1), .col_o(wc0)
  );

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      em_d[r*3+0] = (ctl_q.row_ok[r] && ctl_q.col_ok[0]) ? wc1[r] : '0;
      em_d[r*3+1] = (ctl_q.row_ok[r] && ctl_q.col_ok[1]) ? wc2[r] : '0;
      em_d[r*3+2] = (ctl_q.row_ok[r] && ctl_q.col_ok[2] && !ctl_q.zero_col) ?
                    new_col[r] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_v_q <= 1'b0;
    end else begin
      em_v_q <= (state_q == S_EX) && ctl_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    em_q    <= em_d;
    em_fe_q <= ctl_q.fe;
  end

  sem_grad u_grad (
    .clk_i, .rst_ni, .valid_i(em_v_q), .fe_i(em_fe_q), .win_i(em_q),
    .busy_o(grad_busy), .word_o(chain[0])
  );

  for (genvar i = 0; i < ROOT_W; i++) begin : g_root
    sem_sqrt_cell u_cell (
      .clk_i, .rst_ni,
      .bit_i(ROOT_W'(1) << (ROOT_W - 1 - i)),
      .word_i(chain[i]),
      .word_o(chain[i+1])
    );
  end

  always_comb begin
    pipe_busy = (state_q != S_IDLE) || em_v_q || grad_busy;
    for (int i = 0; i <= ROOT_W; i++) begin
      pipe_busy = pipe_busy || chain[i].valid;
    end
  end

  // round half up: n + 1 when s > n^2 + n
  always_comb begin
    res_v  = chain[ROOT_W].valid;
    res.fe = chain[ROOT_W].fe;
    lim    = '0;
    rnd    = '0;
    for (int ch = 0; ch < 3; ch++) begin
      lim = (SQ_W+1)'(chain[ROOT_W].lane[ch].n) * (SQ_W+1)'(chain[ROOT_W].lane[ch].n)
            + (SQ_W+1)'(chain[ROOT_W].lane[ch].n);
      rnd = {1'b0, chain[ROOT_W].lane[ch].n} +
            (ROOT_W+1)'({1'b0, chain[ROOT_W].lane[ch].s} > lim);
      res.edge_px[ch] = chain[ROOT_W].lane[ch].sat ? CH_W'(255) : rnd[CH_W-1:0];
    end
  end

  assign pop = out_v_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (res_v) begin
      if (!out_v_q || pop) begin
        out_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (pop) begin
      if (skid_v_q) begin
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_v) begin
      if (!out_v_q || pop) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end else if (pop && skid_v_q) begin
      out_q <= skid_q;
    end
  end

  assign out_valid_o  = out_v_q;
  assign red_edge_o   = out_q.edge_px[0];
  assign green_edge_o = out_q.edge_px[1];
  assign blue_edge_o  = out_q.edge_px[2];
  assign frame_end_o  = out_q.fe;

  `SEM_ASSERT_ALWAYS(a_skid_behind_out, clk_i, skid_v_q |-> out_v_q)
  `SEM_ASSERT(a_ready_pipe_empty, clk_i, rst_ni, in_ready_o |-> !pipe_busy)
  `SEM_ASSERT(a_res_skid_free, clk_i, rst_ni, res_v |-> !skid_v_q)
  `SEM_ASSERT(a_pend_bound, clk_i, rst_ni, pend_q <= ew1)
  `SEM_ASSERT(a_ex_entry, clk_i, rst_ni, (state_q == S_EX) |-> ($past(in_acc) || $past(state_q == S_PRE)))

endmodule

`default_nettype wire
